// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file lpb_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted
`define LPB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset
`define LPB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lpb_pkg.sv =====
// Shared widths and constants for the largest-prime-below search
package lpb_pkg;

  localparam int unsigned FIELD_W           = 32;
  localparam int unsigned VALUE_WIDTH_DEF   = 32;

  localparam int unsigned MIN_PRIME         = 2;
  localparam int unsigned FIRST_DIVISOR     = 3;
  localparam int unsigned FIRST_COMPOSITE   = 4;
  localparam int unsigned SECOND_DIVISOR    = 5;
  localparam int unsigned STEP_SHORT        = 2;
  localparam int unsigned STEP_LONG         = 4;

endpackage

// ===== rtl/core/largest_prime_below.sv =====
// Largest prime strictly below an unsigned bound, by 6k+-1 trial division
//
// Input channel in_valid/in_ready carries one word: in_upper_bound.
// Result channel out_valid/out_ready carries out_prime and out_too_small.
// A bound of 0, 1 or 2 gives out_too_small = 1 and out_prime = 0.
// One item is taken at a time; in_ready is high only while the block is idle.
// Each trial division runs a restoring divider in ST_DIV, then ST_CHECK judges
// the quotient and remainder. An even candidate is stepped down in ST_TEST;
// an odd candidate is divided by each trial divisor in turn, about
// sqrt(candidate) / 3 + 2 divisors for a prime. Candidates run from bound - 1
// down to the prime found, which ST_FINISH then loads into the result.
// The result sits in an output register, so the block goes idle and may take
// the next word while the receiver stalls; a second result then waits until
// the first is taken. Reset (rst_n low, synchronous) drops any search in
// progress and clears out_valid.
module largest_prime_below #(
  parameter int unsigned VALUE_WIDTH = lpb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpb_pkg::FIELD_W-1:0] in_upper_bound,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpb_pkg::FIELD_W-1:0] out_prime,
  output logic                        out_too_small
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TEST   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]       cand_r, cand_nxt;
  logic                         small_r, small_nxt;
  logic [VALUE_WIDTH-1:0]       div_r, div_nxt;
  logic                         step_long_r, step_long_nxt;
  logic [VALUE_WIDTH-1:0]       quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lpb_pkg::FIELD_W-1:0]  out_prime_r, out_prime_nxt;
  logic                         out_small_r, out_small_nxt;

  logic [VALUE_WIDTH-1:0]       bound_w;
  logic [VALUE_WIDTH:0]         rem_shift;
  logic                         rem_ge;
  logic [VALUE_WIDTH:0]         rem_diff;
  logic                         out_free;

  assign bound_w   = VALUE_WIDTH'(in_upper_bound);
  assign rem_shift = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_r};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign out_free  = !out_valid_r || out_ready;

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_prime     = out_prime_r;
  assign out_too_small = out_small_r;

  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    small_nxt     = small_r;
    div_nxt       = div_r;
    step_long_nxt = step_long_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_prime_nxt = out_prime_r;
    out_small_nxt = out_small_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (bound_w <= VALUE_WIDTH'(lpb_pkg::MIN_PRIME)) begin
            cand_nxt  = '0;
            small_nxt = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            cand_nxt  = bound_w - VALUE_WIDTH'(1);
            small_nxt = 1'b0;
            state_nxt = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        priority if (cand_r < VALUE_WIDTH'(lpb_pkg::FIRST_COMPOSITE)) begin
          state_nxt = ST_FINISH;
        end else if (!cand_r[0]) begin
          cand_nxt = cand_r - VALUE_WIDTH'(1);
        end else begin
          div_nxt       = VALUE_WIDTH'(lpb_pkg::FIRST_DIVISOR);
          step_long_nxt = 1'b0;
          quo_nxt       = cand_r;
          rem_nxt       = '0;
          cnt_nxt       = CNT_W'(VALUE_WIDTH - 1);
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_nxt = rem_diff[VALUE_WIDTH-1:0];
        end else begin
          rem_nxt = rem_shift[VALUE_WIDTH-1:0];
        end
        quo_nxt = {quo_r[VALUE_WIDTH-2:0], rem_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (div_r > quo_r) begin
          state_nxt = ST_FINISH;
        end else if (rem_r == '0) begin
          cand_nxt  = cand_r - VALUE_WIDTH'(1);
          state_nxt = ST_TEST;
        end else begin
          if (div_r == VALUE_WIDTH'(lpb_pkg::FIRST_DIVISOR)) begin
            div_nxt = VALUE_WIDTH'(lpb_pkg::SECOND_DIVISOR);
          end else if (step_long_r) begin
            div_nxt       = div_r + VALUE_WIDTH'(lpb_pkg::STEP_LONG);
            step_long_nxt = 1'b0;
          end else begin
            div_nxt       = div_r + VALUE_WIDTH'(lpb_pkg::STEP_SHORT);
            step_long_nxt = 1'b1;
          end
          quo_nxt   = cand_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_WIDTH - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_prime_nxt = lpb_pkg::FIELD_W'(cand_r);
          out_small_nxt = small_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    small_r     <= small_nxt;
    div_r       <= div_nxt;
    step_long_r <= step_long_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_prime_r <= out_prime_nxt;
    out_small_r <= out_small_nxt;
  end

endmodule

// ===== rtl/core/lpb_checker.sv =====
// Port-level assertion checker for largest_prime_below, with its bind
`include "assert_macros.svh"

module lpb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [lpb_pkg::FIELD_W-1:0] out_prime,
  input logic                        out_too_small
);

  `LPB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_prime) && $stable(out_too_small), "stalled result word changed")
  `LPB_ASSERT(a_small_zero, out_valid && out_too_small |-> out_prime == '0, "too_small result carries a nonzero prime")
  `LPB_ASSERT(a_prime_min, out_valid && !out_too_small |-> out_prime >= lpb_pkg::FIELD_W'(lpb_pkg::MIN_PRIME), "prime result below two")
  `LPB_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "ready right after taking a word")

endmodule

bind largest_prime_below lpb_checker u_lpb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_prime     (out_prime),
  .out_too_small (out_too_small)
);
